FILE: hw/rtl/twst_pkg.sv
// Shared types and constants of the TCP window scale tagger.
package twst_pkg;

  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [3:0]  MAX_WSCALE   = 4'd14;
  localparam logic [15:0] PORT_A_RESET = 16'd5001;
  localparam logic [15:0] PORT_B_RESET = 16'd80;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Register indexes of the configuration port.
  localparam cfg_idx_t CFG_PORT_A = 1'd0;
  localparam cfg_idx_t CFG_PORT_B = 1'd1;

  typedef logic [31:0] ip_addr_t;
  typedef logic [15:0] tcp_port_t;
  typedef logic [3:0]  wscale_t;

endpackage

FILE: hw/rtl/tcp_window_scale_tagger_unit.sv
// Top level of the TCP window scale tagger: address tables, pair scale memory and control.
//
// Usage: one packet's parsed header fields are transferred at a rising clock
// edge where start_i is high and busy_o is low. Exactly one result per packet
// leaves on write_reserved_o, scale_out_o and table_full_o, valid for the one
// cycle in which done_o is high; the receiver always takes it and cannot stall.
// Configuration (the two watched ports) goes through cfg_we_i, cfg_idx_i and cfg_data_i,
// one register per edge; the user is to write only while idle, not enforced by the block.
// A packet that is not tracked TCP, or carries neither SYN nor ACK, gives its
// all-zero result in the cycle after the transfer and busy_o stays low.
// A tracked SYN or ACK scans both address memories one entry per cycle, in
// parallel, through the larger of the two fill counts (U entries), then passes
// ST_RESOLVE and ST_PAIR, where a SYN writes its pair scale; an ACK reads it in
// ST_PAIR and gives its result from ST_RESP. busy_o falls in the cycle where
// done_o is high, so the next packet can be transferred at the edge that ends
// that cycle. The wait grows with U, as each address memory has one read port.
// After reset the pair scale memory is cleared one entry per cycle, over all
// SOURCE_ENTRIES * DEST_ENTRIES entries (4096 by default); busy_o is high over
// that pass, configuration writes are still taken.
module tcp_window_scale_tagger_unit #(
  parameter int unsigned SOURCE_ENTRIES = 64,
  parameter int unsigned DEST_ENTRIES   = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  twst_pkg::cfg_idx_t  cfg_idx_i,
  input  twst_pkg::cfg_data_t cfg_data_i,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [31:0]         source_address_i,
  input  logic [31:0]         dest_address_i,
  input  logic [7:0]          ip_protocol_i,
  input  logic [15:0]         source_port_i,
  input  logic [15:0]         dest_port_i,
  input  logic                syn_bit_i,
  input  logic                ack_bit_i,
  input  logic                wscale_present_i,
  input  logic [3:0]          wscale_shift_i,
  output logic                done_o,
  output logic                write_reserved_o,
  output logic [3:0]          scale_out_o,
  output logic                table_full_o
);
  import twst_pkg::*;

  localparam int unsigned PAIR_DEPTH = SOURCE_ENTRIES * DEST_ENTRIES;
  localparam int unsigned SRC_AW  = (SOURCE_ENTRIES > 1) ? $clog2(SOURCE_ENTRIES) : 1;
  localparam int unsigned DST_AW  = (DEST_ENTRIES > 1) ? $clog2(DEST_ENTRIES) : 1;
  localparam int unsigned PAIR_AW = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
  localparam int unsigned SCW = $clog2(SOURCE_ENTRIES + 1);
  localparam int unsigned DCW = $clog2(DEST_ENTRIES + 1);
  localparam int unsigned KW  = (SCW > DCW) ? SCW : DCW;

  localparam logic [SCW-1:0]     SRC_FULL  = SCW'(SOURCE_ENTRIES);
  localparam logic [DCW-1:0]     DST_FULL  = DCW'(DEST_ENTRIES);
  localparam logic [PAIR_AW-1:0] PAIR_LAST = PAIR_AW'(PAIR_DEPTH - 1);
  localparam logic [PAIR_AW-1:0] PAIR_ROW  = PAIR_AW'(DEST_ENTRIES);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_RESOLVE,
    ST_PAIR,
    ST_RESP
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  tcp_port_t port_a_q, port_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_a_q <= PORT_A_RESET;
      port_b_q <= PORT_B_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PORT_A: port_a_q <= cfg_data_i;
        CFG_PORT_B: port_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Captured packet.
  ip_addr_t saddr_q, daddr_q;
  wscale_t  wscale_q;
  logic     is_syn_q;

  logic    accept;
  logic    tracked;
  wscale_t wscale_clamped;

  assign accept  = start_i && (state_q == ST_IDLE);
  assign tracked = (ip_protocol_i == PROTO_TCP) &&
                   (source_port_i == port_a_q || dest_port_i == port_a_q ||
                    source_port_i == port_b_q || dest_port_i == port_b_q);
  assign wscale_clamped = !wscale_present_i ? 4'd0 :
                          (wscale_shift_i > MAX_WSCALE) ? MAX_WSCALE : wscale_shift_i;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      saddr_q  <= source_address_i;
      daddr_q  <= dest_address_i;
      wscale_q <= wscale_clamped;
      is_syn_q <= syn_bit_i;
    end
  end

  // Control registers.
  logic [SCW-1:0]     src_used_q, src_used_d;
  logic [DCW-1:0]     dst_used_q, dst_used_d;
  logic [KW-1:0]      k_q, k_d;
  logic [KW-1:0]      cmp_k_q, cmp_k_d;
  logic               rd_vld_q, rd_vld_d;
  logic               src_hit_q, src_hit_d;
  logic               dst_hit_q, dst_hit_d;
  logic [SRC_AW-1:0]  src_idx_q, src_idx_d;
  logic [DST_AW-1:0]  dst_idx_q, dst_idx_d;
  logic               pair_ok_q, pair_ok_d;
  logic               full_q, full_d;
  logic [PAIR_AW-1:0] clr_q, clr_d;
  logic               done_q, done_d;
  logic               wr_q, wr_d;
  wscale_t            sc_q, sc_d;
  logic               tfull_q, tfull_d;

  // Memory ports.
  logic               addr_rd_en;
  logic [SRC_AW-1:0]  src_raddr;
  logic [DST_AW-1:0]  dst_raddr;
  ip_addr_t           src_rdata_q, dst_rdata_q;
  logic               src_we, dst_we;
  logic               scl_we, scl_re;
  logic [PAIR_AW-1:0] scl_waddr, pair_addr;
  wscale_t            scl_wdata, scl_rdata_q;

  logic [KW-1:0] max_used;
  logic          src_room, dst_room;

  assign max_used = (KW'(src_used_q) > KW'(dst_used_q)) ? KW'(src_used_q) : KW'(dst_used_q);
  assign src_raddr = (k_q < KW'(SOURCE_ENTRIES)) ? k_q[SRC_AW-1:0] : '0;
  assign dst_raddr = (k_q < KW'(DEST_ENTRIES)) ? k_q[DST_AW-1:0] : '0;
  assign src_room  = src_used_q < SRC_FULL;
  assign dst_room  = dst_used_q < DST_FULL;
  assign pair_addr = PAIR_AW'(src_idx_q) * PAIR_ROW + PAIR_AW'(dst_idx_q);

  always_comb begin
    state_d    = state_q;
    src_used_d = src_used_q;
    dst_used_d = dst_used_q;
    k_d        = k_q;
    cmp_k_d    = cmp_k_q;
    rd_vld_d   = 1'b0;
    src_hit_d  = src_hit_q;
    dst_hit_d  = dst_hit_q;
    src_idx_d  = src_idx_q;
    dst_idx_d  = dst_idx_q;
    pair_ok_d  = pair_ok_q;
    full_d     = full_q;
    clr_d      = clr_q;
    done_d     = 1'b0;
    wr_d       = 1'b0;
    sc_d       = '0;
    tfull_d    = 1'b0;
    addr_rd_en = 1'b0;
    src_we     = 1'b0;
    dst_we     = 1'b0;
    scl_we     = 1'b0;
    scl_re     = 1'b0;
    scl_waddr  = pair_addr;
    scl_wdata  = wscale_q;

    case (state_q)
      ST_CLEAR: begin
        scl_we    = 1'b1;
        scl_waddr = clr_q;
        scl_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == PAIR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (tracked && (syn_bit_i || ack_bit_i)) begin
            state_d   = ST_SEARCH;
            k_d       = '0;
            src_hit_d = 1'b0;
            dst_hit_d = 1'b0;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        // Reads are issued one entry ahead of the compare of the returned data.
        if (rd_vld_q) begin
          if (!src_hit_q && (KW'(cmp_k_q) < KW'(src_used_q)) && src_rdata_q == saddr_q) begin
            src_hit_d = 1'b1;
            src_idx_d = cmp_k_q[SRC_AW-1:0];
          end
          if (!dst_hit_q && (KW'(cmp_k_q) < KW'(dst_used_q)) && dst_rdata_q == daddr_q) begin
            dst_hit_d = 1'b1;
            dst_idx_d = cmp_k_q[DST_AW-1:0];
          end
        end
        if (k_q < max_used) begin
          addr_rd_en = 1'b1;
          rd_vld_d   = 1'b1;
          cmp_k_d    = k_q;
          k_d        = k_q + 1'b1;
        end else if (!rd_vld_q) begin
          state_d = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        state_d = ST_PAIR;
        if (is_syn_q) begin
          if (!src_hit_q) begin
            src_idx_d = src_used_q[SRC_AW-1:0];
            if (src_room) begin
              src_we     = 1'b1;
              src_used_d = src_used_q + 1'b1;
            end
          end
          if (!dst_hit_q) begin
            dst_idx_d = dst_used_q[DST_AW-1:0];
            if (dst_room) begin
              dst_we     = 1'b1;
              dst_used_d = dst_used_q + 1'b1;
            end
          end
          pair_ok_d = (src_hit_q || src_room) && (dst_hit_q || dst_room);
          full_d    = (!src_hit_q && !src_room) || (!dst_hit_q && !dst_room);
        end else begin
          pair_ok_d = src_hit_q && dst_hit_q;
          full_d    = 1'b0;
        end
      end
      ST_PAIR: begin
        if (is_syn_q) begin
          scl_we  = pair_ok_q;
          done_d  = 1'b1;
          tfull_d = full_q;
          state_d = ST_IDLE;
        end else begin
          scl_re  = pair_ok_q;
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        done_d  = 1'b1;
        if (pair_ok_q && scl_rdata_q != '0) begin
          wr_d = 1'b1;
          sc_d = scl_rdata_q;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      src_used_q <= '0;
      dst_used_q <= '0;
      k_q        <= '0;
      cmp_k_q    <= '0;
      rd_vld_q   <= 1'b0;
      src_hit_q  <= 1'b0;
      dst_hit_q  <= 1'b0;
      src_idx_q  <= '0;
      dst_idx_q  <= '0;
      pair_ok_q  <= 1'b0;
      full_q     <= 1'b0;
      clr_q      <= '0;
      done_q     <= 1'b0;
      wr_q       <= 1'b0;
      sc_q       <= '0;
      tfull_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      src_used_q <= src_used_d;
      dst_used_q <= dst_used_d;
      k_q        <= k_d;
      cmp_k_q    <= cmp_k_d;
      rd_vld_q   <= rd_vld_d;
      src_hit_q  <= src_hit_d;
      dst_hit_q  <= dst_hit_d;
      src_idx_q  <= src_idx_d;
      dst_idx_q  <= dst_idx_d;
      pair_ok_q  <= pair_ok_d;
      full_q     <= full_d;
      clr_q      <= clr_d;
      done_q     <= done_d;
      wr_q       <= wr_d;
      sc_q       <= sc_d;
      tfull_q    <= tfull_d;
    end
  end

  // Address memories.
  ip_addr_t src_mem [SOURCE_ENTRIES];
  ip_addr_t dst_mem [DEST_ENTRIES];

  always_ff @(posedge clk_i) begin
    if (src_we) begin
      src_mem[src_used_q[SRC_AW-1:0]] <= saddr_q;
    end
    if (addr_rd_en) begin
      src_rdata_q <= src_mem[src_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dst_we) begin
      dst_mem[dst_used_q[DST_AW-1:0]] <= daddr_q;
    end
    if (addr_rd_en) begin
      dst_rdata_q <= dst_mem[dst_raddr];
    end
  end

  // Pair scale memory, indexed by source index times row length plus dest index.
  wscale_t scl_mem [PAIR_DEPTH];

  always_ff @(posedge clk_i) begin
    if (scl_we) begin
      scl_mem[scl_waddr] <= scl_wdata;
    end
    if (scl_re) begin
      scl_rdata_q <= scl_mem[pair_addr];
    end
  end

  assign busy_o           = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign write_reserved_o = wr_q;
  assign scale_out_o      = sc_q;
  assign table_full_o     = tfull_q;

  // A pair entry is only written or read for indexes that are already in the tables.
  a_pair_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAIR && pair_ok_q) |->
      (SCW'(src_idx_q) < src_used_q) && (DCW'(dst_idx_q) < dst_used_q))
    else $error("pair scale access outside the filled table entries");

  a_used_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_RESOLVE) |=> (src_used_q == $past(src_used_q)) &&
                                (dst_used_q == $past(dst_used_q)))
    else $error("fill count changed outside the insert step");

  a_no_result_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !done_o)
    else $error("result issued during the clearing pass");

  a_flags_with_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (table_full_o || write_reserved_o) |-> done_o && !(table_full_o && write_reserved_o))
    else $error("result flags raised without a result transfer");

endmodule

FILE: test/tcp_window_scale_tagger_unit_tb.sv
// Self-checking testbench of the TCP window scale tagger, with a scoreboard class and drivers.
`timescale 1ns / 1ps

module tcp_window_scale_tagger_unit_tb;
  import twst_pkg::*;

  localparam int SRC_DEPTH   = 64;
  localparam int DST_DEPTH   = 64;
  localparam int POOL_DEPTH  = 160;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    ip_addr_t   saddr;
    ip_addr_t   daddr;
    logic [7:0] proto;
    tcp_port_t  sport;
    tcp_port_t  dport;
    logic       syn;
    logic       ack;
    logic       present;
    wscale_t    shift;
  } pkt_t;

  typedef struct {
    logic    write_reserved;
    wscale_t scale;
    logic    full;
  } tag_t;

  typedef struct {
    ip_addr_t s;
    ip_addr_t d;
  } flow_t;

  class scale_scoreboard;
    tcp_port_t port_a;
    tcp_port_t port_b;
    ip_addr_t  src_tab [SRC_DEPTH];
    ip_addr_t  dst_tab [DST_DEPTH];
    int        src_cnt;
    int        dst_cnt;
    bit [3:0]  pair_mem [SRC_DEPTH*DST_DEPTH];
    tag_t      pending_tags [$];
    int        errors;
    int        n_pkts;
    int        n_syn;
    int        n_hit;
    int        n_full;
    int        n_passthru;

    function new();
      port_a     = PORT_A_RESET;
      port_b     = PORT_B_RESET;
      src_cnt    = 0;
      dst_cnt    = 0;
      errors     = 0;
      n_pkts     = 0;
      n_syn      = 0;
      n_hit      = 0;
      n_full     = 0;
      n_passthru = 0;
    endfunction

    function void set_port(cfg_idx_t idx, cfg_data_t val);
      case (idx)
        CFG_PORT_A: port_a = val;
        CFG_PORT_B: port_b = val;
        default: ;
      endcase
    endfunction

    function int find_addr(bit dest_side, ip_addr_t a);
      if (dest_side) begin
        for (int k = 0; k < dst_cnt; k++) if (dst_tab[k] == a) return k;
      end else begin
        for (int k = 0; k < src_cnt; k++) if (src_tab[k] == a) return k;
      end
      return -1;
    endfunction

    // Works out the tag of one transferred packet and updates the tables.
    function void note_packet(pkt_t p);
      tag_t t;
      int   si;
      int   di;
      bit   tracked;
      t = '{default: '0};
      n_pkts++;
      tracked = (p.proto == PROTO_TCP) &&
                (p.sport == port_a || p.dport == port_a ||
                 p.sport == port_b || p.dport == port_b);
      if (tracked && p.syn) begin
        n_syn++;
        si = find_addr(1'b0, p.saddr);
        di = find_addr(1'b1, p.daddr);
        if (si < 0) begin
          if (src_cnt < SRC_DEPTH) begin
            si = src_cnt;
            src_tab[src_cnt] = p.saddr;
            src_cnt++;
          end else begin
            t.full = 1'b1;
          end
        end
        if (di < 0) begin
          if (dst_cnt < DST_DEPTH) begin
            di = dst_cnt;
            dst_tab[dst_cnt] = p.daddr;
            dst_cnt++;
          end else begin
            t.full = 1'b1;
          end
        end
        if (si >= 0 && di >= 0) begin
          if (!p.present) pair_mem[si*DST_DEPTH+di] = 4'd0;
          else pair_mem[si*DST_DEPTH+di] = (p.shift > MAX_WSCALE) ? MAX_WSCALE : p.shift;
        end
        if (t.full) n_full++;
      end else if (tracked && p.ack) begin
        si = find_addr(1'b0, p.saddr);
        di = find_addr(1'b1, p.daddr);
        if (si >= 0 && di >= 0 && pair_mem[si*DST_DEPTH+di] != 4'd0) begin
          t.write_reserved = 1'b1;
          t.scale = pair_mem[si*DST_DEPTH+di];
          n_hit++;
        end
      end else begin
        n_passthru++;
      end
      pending_tags.push_back(t);
    endfunction

    function void check_result(logic wr, wscale_t sc, logic full);
      tag_t t;
      if (pending_tags.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: wr=%0b scale=%0d full=%0b",
                 $time, wr, sc, full);
        return;
      end
      t = pending_tags.pop_front();
      if (wr !== t.write_reserved || sc !== t.scale || full !== t.full) begin
        errors++;
        $display("%0t: mismatch: expected wr=%0b scale=%0d full=%0b,",
                 $time, t.write_reserved, t.scale, t.full,
                 " actual wr=%0b scale=%0d full=%0b", wr, sc, full);
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  cfg_idx_t   cfg_idx_i;
  cfg_data_t  cfg_data_i;
  logic       start_i;
  logic       busy_o;
  ip_addr_t   source_address_i;
  ip_addr_t   dest_address_i;
  logic [7:0] ip_protocol_i;
  tcp_port_t  source_port_i;
  tcp_port_t  dest_port_i;
  logic       syn_bit_i;
  logic       ack_bit_i;
  logic       wscale_present_i;
  wscale_t    wscale_shift_i;
  logic       done_o;
  logic       write_reserved_o;
  wscale_t    scale_out_o;
  logic       table_full_o;

  scale_scoreboard sb = new();

  ip_addr_t src_pool [POOL_DEPTH];
  ip_addr_t dst_pool [POOL_DEPTH];
  flow_t    recent_flows [$];
  int       pool_span = 16;
  int       idle_pct = 9;
  int       stall_cycles = 0;

  tcp_window_scale_tagger_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .source_address_i (source_address_i),
    .dest_address_i   (dest_address_i),
    .ip_protocol_i    (ip_protocol_i),
    .source_port_i    (source_port_i),
    .dest_port_i      (dest_port_i),
    .syn_bit_i        (syn_bit_i),
    .ack_bit_i        (ack_bit_i),
    .wscale_present_i (wscale_present_i),
    .wscale_shift_i   (wscale_shift_i),
    .done_o           (done_o),
    .write_reserved_o (write_reserved_o),
    .scale_out_o      (scale_out_o),
    .table_full_o     (table_full_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(write_reserved_o, scale_out_o, table_full_o);
  end

  // Any transfer in either direction, or a register write, counts as progress.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d cycles without progress", STALL_LIMIT);
      $display("FAIL tcp_window_scale_tagger_unit");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic pkt_t mk(ip_addr_t sa, ip_addr_t da, logic [7:0] proto,
                              tcp_port_t sp, tcp_port_t dp, logic syn, logic ack,
                              logic present, wscale_t shift);
    pkt_t p;
    p = '{sa, da, proto, sp, dp, syn, ack, present, shift};
    return p;
  endfunction

  // Most packets are well-formed tracked traffic; ACKs mostly revisit recent SYN flows.
  function automatic pkt_t make_packet();
    pkt_t  p;
    flow_t f;
    int    roll;
    p.saddr   = $urandom;
    p.daddr   = $urandom;
    p.proto   = 8'($urandom);
    p.sport   = 16'($urandom);
    p.dport   = 16'($urandom);
    p.syn     = 1'($urandom);
    p.ack     = 1'($urandom);
    p.present = 1'($urandom);
    p.shift   = 4'($urandom);
    roll = $urandom_range(99);
    if (roll < 85) begin
      p.proto = PROTO_TCP;
      case ($urandom_range(3))
        0: p.sport = sb.port_a;
        1: p.dport = sb.port_a;
        2: p.sport = sb.port_b;
        default: p.dport = sb.port_b;
      endcase
      p.saddr = src_pool[$urandom_range(pool_span-1)];
      p.daddr = dst_pool[$urandom_range(pool_span-1)];
      roll = $urandom_range(99);
      if (roll < 35) begin
        p.syn = 1'b1;
        p.present = ($urandom_range(9) != 0);
        f = '{p.saddr, p.daddr};
        recent_flows.push_back(f);
        if (recent_flows.size() > 32) void'(recent_flows.pop_front());
      end else if (roll < 90) begin
        p.syn = 1'b0;
        p.ack = 1'b1;
        if (recent_flows.size() != 0 && $urandom_range(99) < 75) begin
          f = recent_flows[$urandom_range(recent_flows.size()-1)];
          p.saddr = f.s;
          p.daddr = f.d;
        end
      end else begin
        p.syn = 1'b0;
        p.ack = 1'b0;
      end
    end else if (roll < 92) begin
      p.proto = PROTO_TCP;
    end
    return p;
  endfunction

  task automatic send_packet(pkt_t p);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i          <= 1'b1;
    source_address_i <= p.saddr;
    dest_address_i   <= p.daddr;
    ip_protocol_i    <= p.proto;
    source_port_i    <= p.sport;
    dest_port_i      <= p.dport;
    syn_bit_i        <= p.syn;
    ack_bit_i        <= p.ack;
    wscale_present_i <= p.present;
    wscale_shift_i   <= p.shift;
    do @(posedge clk_i); while (busy_o);
    sb.note_packet(p);
  endtask

  task automatic wait_drain();
    start_i <= 1'b0;
    while (sb.pending_tags.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_ports(cfg_data_t a, cfg_data_t b);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_PORT_A;
    cfg_data_i <= a;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_PORT_B;
    cfg_data_i <= b;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_port(CFG_PORT_A, a);
    sb.set_port(CFG_PORT_B, b);
  endtask

  task automatic run_random(int count, int span, int idle);
    pool_span = span;
    idle_pct  = idle;
    repeat (count) send_packet(make_packet());
  endtask

  initial begin
    for (int k = 0; k < POOL_DEPTH; k++) begin
      src_pool[k] = $urandom;
      dst_pool[k] = $urandom;
    end
    src_pool[0] = '0;
    src_pool[1] = '1;
    dst_pool[0] = '0;
    dst_pool[1] = '1;

    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CFG_PORT_A;
    cfg_data_i       <= '0;
    start_i          <= 1'b0;
    source_address_i <= '0;
    dest_address_i   <= '0;
    ip_protocol_i    <= '0;
    source_port_i    <= '0;
    dest_port_i      <= '0;
    syn_bit_i        <= 1'b0;
    ack_bit_i        <= 1'b0;
    wscale_present_i <= 1'b0;
    wscale_shift_i   <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed packets with the ports left at their reset values.
    send_packet(mk(32'h0A00_0001, 32'h0A00_0002, 8'd17, 16'd5001, 16'd80, 1, 0, 1, 4'd5));
    send_packet(mk(32'h0A00_0001, 32'h0A00_0002, PROTO_TCP, 16'd1234, 16'd4321, 1, 1, 1, 4'd5));
    send_packet(mk(32'h0, 32'hFFFF_FFFF, PROTO_TCP, 16'd5001, 16'd999, 1, 0, 1, 4'd7));
    send_packet(mk(32'h0, 32'hFFFF_FFFF, PROTO_TCP, 16'd5001, 16'd999, 0, 1, 0, 4'd0));
    send_packet(mk(32'hFFFF_FFFF, 32'h0, PROTO_TCP, 16'd999, 16'd80, 1, 1, 1, 4'd15));
    send_packet(mk(32'hFFFF_FFFF, 32'h0, PROTO_TCP, 16'd999, 16'd80, 0, 1, 1, 4'd15));
    send_packet(mk(32'h0, 32'h0, PROTO_TCP, 16'd7, 16'd5001, 1, 0, 0, 4'd9));
    send_packet(mk(32'h0, 32'h0, PROTO_TCP, 16'd7, 16'd5001, 0, 1, 0, 4'd9));
    send_packet(mk(32'h1234_5678, 32'h0, PROTO_TCP, 16'd80, 16'd80, 0, 1, 1, 4'd3));
    send_packet(mk(32'h0, 32'hFFFF_FFFF, PROTO_TCP, 16'd5001, 16'd80, 0, 0, 1, 4'd3));
    send_packet(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, PROTO_TCP, 16'd80, 16'd1, 1, 0, 1, 4'd14));
    send_packet(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, PROTO_TCP, 16'd80, 16'd1, 0, 1, 0, 4'd0));
    send_packet(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, PROTO_TCP, 16'd2, 16'd80, 1, 0, 1, 4'd0));
    send_packet(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, PROTO_TCP, 16'd2, 16'd80, 0, 1, 1, 4'd0));
    send_packet(mk(32'h0, 32'hFFFF_FFFF, 8'd0, 16'd80, 16'd5001, 1, 1, 1, 4'd15));
    send_packet(mk(32'h0, 32'hFFFF_FFFF, 8'd255, 16'd80, 16'd5001, 0, 1, 1, 4'd15));
    send_packet(mk(32'h0, 32'hFFFF_FFFF, PROTO_TCP, 16'd5001, 16'd80, 1, 0, 1, 4'd3));
    send_packet(mk(32'h0, 32'hFFFF_FFFF, PROTO_TCP, 16'd5001, 16'd80, 0, 1, 0, 4'd0));
    wait_drain();

    // Port extremes; the old ports must no longer be tracked.
    write_ports(16'd0, 16'hFFFF);
    send_packet(mk(32'h0, 32'hFFFF_FFFF, PROTO_TCP, 16'd0, 16'd5001, 1, 0, 1, 4'd1));
    send_packet(mk(32'h0, 32'hFFFF_FFFF, PROTO_TCP, 16'd42, 16'hFFFF, 0, 1, 0, 4'd0));
    send_packet(mk(32'h0, 32'hFFFF_FFFF, PROTO_TCP, 16'd5001, 16'd80, 0, 1, 0, 4'd0));
    send_packet(mk(32'hFFFF_FFFF, 32'h0, PROTO_TCP, 16'hFFFF, 16'd0, 1, 1, 1, 4'd15));
    run_random(350, 24, 9);
    wait_drain();

    // This phase runs without any idle cycles on the sending side.
    write_ports(16'hFFFF, 16'd0);
    run_random(400, 48, 0);
    wait_drain();

    // The wide address pool overflows both tables.
    write_ports(cfg_data_t'($urandom), cfg_data_t'($urandom));
    run_random(500, POOL_DEPTH, 9);
    wait_drain();
    repeat (80) @(posedge clk_i);

    if (sb.pending_tags.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.pending_tags.size());
    end
    $display("Sent %0d packets over four port settings: %0d SYN stores, %0d reserved-bit writes,",
             sb.n_pkts, sb.n_syn, sb.n_hit);
    $display("%0d table-full flags, %0d ignored packets; tables hold %0d source and %0d dest.",
             sb.n_full, sb.n_passthru, sb.src_cnt, sb.dst_cnt);
    if (sb.errors == 0) begin
      $display("PASS tcp_window_scale_tagger_unit");
    end else begin
      $display("FAIL tcp_window_scale_tagger_unit");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/twst_pkg.sv
hw/rtl/tcp_window_scale_tagger_unit.sv
test/tcp_window_scale_tagger_unit_tb.sv
